// File: hdl/filtered_nearest_delta_r_match_core_defines.svh
// Assertion macros for the filtered nearest delta-R match core.
`ifndef FILTERED_NEAREST_DELTA_R_MATCH_CORE_DEFINES_SVH
`define FILTERED_NEAREST_DELTA_R_MATCH_CORE_DEFINES_SVH

// Plain property checked on every rising clock edge outside reset
`define FDRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define FDRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define FDRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/fdrm_pkg.sv
// Package of widths, register indices and reset values for the delta-R match core.
package fdrm_pkg;

  // Field widths
  localparam int ETA_W    = 11;
  localparam int PHI_W    = 10;
  localparam int STATUS_W = 8;
  localparam int ID_W     = 24;
  localparam int RAD_W    = 22;
  localparam int IDX_W    = 10;
  localparam int SQE_W    = 2 * ETA_W;
  localparam int SQP_W    = 2 * PHI_W;
  localparam int DIST_W   = SQE_W + 1;

  // Stream payload widths (whole bytes)
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_EXCL_REGS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS_SQ  = 3'd0,
    CFG_STATUS_OFF = 3'd1,
    CFG_STATUS_WANT = 3'd2,
    CFG_EXCL_A     = 3'd3,
    CFG_EXCL_B     = 3'd4,
    CFG_EXCL_C     = 3'd5,
    CFG_EXCL_D     = 3'd6
  } cfg_idx_t;

  // Input kind codes
  localparam logic KIND_REF  = 1'b0;
  localparam logic KIND_PART = 1'b1;

  // Reset values of the registers
  localparam logic [RAD_W-1:0]    RADIUS_SQ_RST  = 22'd1061;
  localparam logic                STATUS_OFF_RST = 1'b1;
  localparam logic [STATUS_W-1:0] STATUS_WANT_RST = 8'd1;

  // Parameter defaults
  localparam int MAX_LIST_DEF      = 1024;
  localparam int EXCLUDE_SLOTS_DEF = 4;

endpackage

// File: hdl/filtered_nearest_delta_r_match_core.sv
// Filtered nearest delta-R matcher: three-register pipeline with stream ports.
// Path from input transfer to result transfer: input register, squares register,
//   result register; one item per cycle sustained unless a last item waits on the result stream.
// Stages retire independently, so items keep entering while a result waits,
//   until the next last item reaches the squares register and holds there.
// Synchronous active-low reset: registers return to their defaults, reference
//   (0,0), best distance 1061, no match, list position 0, pipeline empty.
module filtered_nearest_delta_r_match_core #(
  parameter int MAX_LIST      = fdrm_pkg::MAX_LIST_DEF,
  parameter int EXCLUDE_SLOTS = fdrm_pkg::EXCLUDE_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: eta_val[10:0], phi_val[20:11], part_status[28:21],
  //        part_id_abs[52:29], zero fill [55:53]
  input  logic [fdrm_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: kind (0 reference, 1 particle)
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: match_found[0], match_index[10:1], zero fill [15:11]
  output logic [fdrm_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [fdrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fdrm_pkg::*;
  `include "filtered_nearest_delta_r_match_core_defines.svh"

  localparam int CNT_W = $clog2(MAX_LIST + 1);
  localparam int POS_W = $clog2(MAX_LIST);

  // ---------------- configuration registers ----------------
  logic [RAD_W-1:0]    radius_sq_r;
  logic                status_off_r;
  logic [STATUS_W-1:0] status_want_r;
  logic [ID_W-1:0]     excl_r [EXCLUDE_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_sq_r   <= RADIUS_SQ_RST;
      status_off_r  <= STATUS_OFF_RST;
      status_want_r <= STATUS_WANT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS_SQ:   radius_sq_r   <= cfg_wdata[RAD_W-1:0];
        CFG_STATUS_OFF:  status_off_r  <= cfg_wdata[0];
        CFG_STATUS_WANT: status_want_r <= cfg_wdata[STATUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Excluded ids; only the first four slots have a register index
  for (genvar k = 0; k < EXCLUDE_SLOTS; k++) begin : g_excl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        excl_r[k] <= '0;
      end else if (cfg_we && (k < NUM_EXCL_REGS)
                   && (cfg_index == CFG_IDX_W'(int'(CFG_EXCL_A) + k))) begin
        excl_r[k] <= cfg_wdata[ID_W-1:0];
      end
    end
  end

  // ---------------- stage handshakes ----------------
  logic s1_v_r, s2_v_r, out_valid_r;
  logic s1_go, s2_go, s1_free, s2_free, out_free;

  assign out_free  = !out_valid_r || out_tready;
  logic s2_last_r;
  assign s2_go     = s2_v_r && (!s2_last_r || out_free);
  assign s2_free   = !s2_v_r || s2_go;
  assign s1_go     = s1_v_r && s2_free;
  assign s1_free   = !s1_v_r || s1_go;
  assign in_tready = s1_free;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // ---------------- stage 1: input register ----------------
  logic                   s1_kind_r, s1_last_r;
  logic signed [ETA_W-1:0] s1_eta_r;
  logic [PHI_W-1:0]       s1_phi_r;
  logic [STATUS_W-1:0]    s1_status_r;
  logic [ID_W-1:0]        s1_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r   <= in_tuser;
      s1_last_r   <= in_tlast;
      s1_eta_r    <= in_tdata[ETA_W-1:0];
      s1_phi_r    <= in_tdata[ETA_W +: PHI_W];
      s1_status_r <= in_tdata[ETA_W+PHI_W +: STATUS_W];
      s1_id_r     <= in_tdata[ETA_W+PHI_W+STATUS_W +: ID_W];
    end
  end

  // Reference point and list position, updated as items leave stage 1
  logic signed [ETA_W-1:0] ref_eta_r;
  logic [PHI_W-1:0]        ref_phi_r;
  logic [CNT_W-1:0]        pos_cnt_r;
  logic [CNT_W-1:0]        pos_cnt_nxt;

  always_comb begin
    pos_cnt_nxt = pos_cnt_r;
    if (s1_kind_r == KIND_REF || s1_last_r) begin
      pos_cnt_nxt = '0;
    end else if (pos_cnt_r < CNT_W'(MAX_LIST)) begin
      pos_cnt_nxt = pos_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_eta_r <= '0;
      ref_phi_r <= '0;
      pos_cnt_r <= '0;
    end else if (s1_go) begin
      pos_cnt_r <= pos_cnt_nxt;
      if (s1_kind_r == KIND_REF) begin
        ref_eta_r <= s1_eta_r;
        ref_phi_r <= s1_phi_r;
      end
    end
  end

  // Filtering: position in range, status match unless status filtering is off, no excluded id
  logic id_hit;
  logic s1_elig;

  always_comb begin
    id_hit = 1'b0;
    for (int k = 0; k < EXCLUDE_SLOTS; k++) begin
      if (excl_r[k] != '0 && excl_r[k] == s1_id_r) id_hit = 1'b1;
    end
    s1_elig = (pos_cnt_r < CNT_W'(MAX_LIST))
              && (status_off_r || (s1_status_r == status_want_r))
              && !id_hit;
  end

  // Distance components: |deta| and phi difference the short way round
  logic signed [ETA_W:0] deta;
  logic [ETA_W-1:0]      ade;
  logic [PHI_W-1:0]      dp_raw, adp;
  logic [SQE_W-1:0]      sq_eta;
  logic [SQP_W-1:0]      sq_phi;

  always_comb begin
    deta   = {s1_eta_r[ETA_W-1], s1_eta_r} - {ref_eta_r[ETA_W-1], ref_eta_r};
    ade    = deta[ETA_W] ? ETA_W'(-deta) : deta[ETA_W-1:0];
    dp_raw = s1_phi_r - ref_phi_r;
    adp    = dp_raw[PHI_W-1] ? PHI_W'((PHI_W+1)'(1 << PHI_W) - {1'b0, dp_raw}) : dp_raw;
    sq_eta = SQE_W'(ade) * SQE_W'(ade);
    sq_phi = SQP_W'(adp) * SQP_W'(adp);
  end

  // ---------------- stage 2: squares register ----------------
  logic              s2_kind_r, s2_elig_r;
  logic [POS_W-1:0]  s2_pos_r;
  logic [SQE_W-1:0]  s2_sq_eta_r;
  logic [SQP_W-1:0]  s2_sq_phi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_kind_r   <= s1_kind_r;
      s2_last_r   <= s1_last_r;
      s2_elig_r   <= s1_elig;
      s2_pos_r    <= pos_cnt_r[POS_W-1:0];
      s2_sq_eta_r <= sq_eta;
      s2_sq_phi_r <= sq_phi;
    end
  end

  // ---------------- best-match tracking ----------------
  logic [RAD_W-1:0] best_dist_r, best_dist_nxt;
  logic [POS_W-1:0] best_pos_r, best_pos_nxt;
  logic             have_r, have_nxt;
  logic [DIST_W-1:0] dist_sum;
  logic              found_new;
  logic [POS_W-1:0]  pos_new;

  always_comb begin
    dist_sum      = DIST_W'(s2_sq_eta_r) + DIST_W'(s2_sq_phi_r);
    best_dist_nxt = best_dist_r;
    best_pos_nxt  = best_pos_r;
    have_nxt      = have_r;
    if (s2_kind_r == KIND_REF) begin
      best_dist_nxt = radius_sq_r;
      best_pos_nxt  = '0;
      have_nxt      = 1'b0;
    end else if (s2_elig_r && (dist_sum < DIST_W'(best_dist_r))) begin
      best_dist_nxt = dist_sum[RAD_W-1:0];
      best_pos_nxt  = s2_pos_r;
      have_nxt      = 1'b1;
    end
    // Result taken from the updated state, then the search restarts
    found_new = have_nxt;
    pos_new   = have_nxt ? best_pos_nxt : '0;
    if (s2_last_r) begin
      best_dist_nxt = radius_sq_r;
      best_pos_nxt  = '0;
      have_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= RADIUS_SQ_RST;
      best_pos_r  <= '0;
      have_r      <= 1'b0;
    end else if (s2_go) begin
      best_dist_r <= best_dist_nxt;
      best_pos_r  <= best_pos_nxt;
      have_r      <= have_nxt;
    end
  end

  // ---------------- result register ----------------
  logic             out_found_r;
  logic [IDX_W-1:0] out_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_last_r) begin
      out_found_r <= found_new;
      out_index_r <= IDX_W'(pos_new);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-IDX_W-1)'(0), out_index_r, out_found_r};

  // ---------------- assertions ----------------
  `FDRM_ASSERT_IMP(a_nomatch_pos_zero, !have_r, best_pos_r == '0, "best position set without a match")
  `FDRM_ASSERT(a_pos_bounded, pos_cnt_r <= CNT_W'(MAX_LIST), "list position beyond MAX_LIST")
  `FDRM_ASSERT_IMP(a_nomatch_index_zero, out_valid_r && !out_found_r, out_index_r == '0, "index nonzero without match")
  `FDRM_ASSERT_NEXT(a_last_held, s2_v_r && s2_last_r && out_valid_r && !out_tready, s2_v_r && s2_last_r, "last item dropped while result stalled")

endmodule
